FILE: hw/rtl/countdown_event_table_assert.svh
// Assertion macros for the countdown event table checker.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef COUNTDOWN_EVENT_TABLE_ASSERT_SVH
`define COUNTDOWN_EVENT_TABLE_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define CET_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset
`define CET_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/cet_pkg.sv
// Shared types and constants for the countdown event table.
// No dependencies; imported by every RTL module of the block.
package cet_pkg;

	localparam int SLOTS      = 16;
	localparam int COUNT_BITS = 16;
	localparam int IDX_W      = $clog2(SLOTS);
	localparam int TAG_W      = 16;

	// Request mode codes
	localparam logic [1:0] MODE_ADD    = 2'd0;
	localparam logic [1:0] MODE_CANCEL = 2'd1;
	localparam logic [1:0] MODE_TICK   = 2'd2;
	localparam logic [1:0] MODE_CLEAR  = 2'd3;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_CANCEL = 2'd1,
		OP_TICK   = 2'd2,
		OP_CLEAR  = 2'd3
	} cet_op_t;

	typedef enum logic [2:0] {
		ST_ADDED     = 3'd0,
		ST_FULL      = 3'd1,
		ST_CANCELLED = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_FIRED     = 3'd4,
		ST_CLEARED   = 3'd5
	} cet_status_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [15:0] delay;
		logic [15:0] tag;
		logic [3:0]  handle;
	} cet_in_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [3:0]  slot;
		logic [15:0] event_tag;
		logic        last;
	} cet_out_t;

	// Classified command passed from front to back
	typedef struct packed {
		cet_op_t               op;
		logic [COUNT_BITS-1:0] delay;
		logic [TAG_W-1:0]      tag;
		logic [3:0]            handle;
		logic                  handle_ok;
	} cet_cmd_t;

endpackage

FILE: hw/rtl/cet_cmd_fifo.sv
// Two-entry command queue between the front and back of the event table.
// Depends on cet_pkg for the command type.
module cet_cmd_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  cet_pkg::cet_cmd_t push_cmd,
	output logic              full,
	input  logic              pop,
	output logic              empty,
	output cet_pkg::cet_cmd_t head
);
	import cet_pkg::*;

	cet_cmd_t   mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign head  = mem_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_cmd;
	end

endmodule

FILE: hw/rtl/cet_front.sv
// Request front end: takes request transfers and classifies them into commands.
// Depends on cet_pkg; feeds cet_cmd_fifo.
module cet_front (
	input  logic              req_valid,
	output logic              req_ready,
	input  cet_pkg::cet_in_t  req,
	input  logic              fifo_full,
	output logic              push,
	output cet_pkg::cet_cmd_t push_cmd
);
	import cet_pkg::*;

	assign req_ready = !fifo_full;
	assign push      = req_valid && req_ready;

	// Decode mode, trim delay to the counter width, range-check the handle
	always_comb begin
		push_cmd.delay     = req.delay[COUNT_BITS-1:0];
		push_cmd.tag       = req.tag;
		push_cmd.handle    = req.handle;
		push_cmd.handle_ok = (int'(req.handle) < SLOTS);
		unique case (req.mode)
			MODE_ADD:    push_cmd.op = OP_ADD;
			MODE_CANCEL: push_cmd.op = OP_CANCEL;
			MODE_TICK:   push_cmd.op = OP_TICK;
			MODE_CLEAR:  push_cmd.op = OP_CLEAR;
			default:     push_cmd.op = OP_CLEAR;
		endcase
	end

endmodule

FILE: hw/rtl/cet_back.sv
// Event table back end: slot storage, command execution, fired-event scan
// and the response register. Depends on cet_pkg.
module cet_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  cet_pkg::cet_cmd_t cmd,
	output logic              pop,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output cet_pkg::cet_out_t rsp
);
	import cet_pkg::*;

	typedef enum logic [1:0] {
		BK_IDLE = 2'b01,
		BK_SCAN = 2'b10
	} bk_state_t;

	bk_state_t             state_q;
	logic [SLOTS-1:0]      live_q;
	logic [SLOTS-1:0]      fire_q;
	logic [IDX_W-1:0]      scan_rank_q;
	logic [COUNT_BITS-1:0] ticks_q [SLOTS];
	logic [TAG_W-1:0]      tag_q   [SLOTS];
	logic [IDX_W-1:0]      rank_q  [SLOTS];
	logic                  out_valid_q;
	cet_out_t              out_q;

	logic             table_full;
	logic [IDX_W-1:0] free_idx;
	logic [SLOTS-1:0] match_vec;
	logic [IDX_W-1:0] match_idx;
	logic             any_match;
	logic             scan_last;
	logic [IDX_W-1:0] hidx;
	logic             hnd_live;
	logic [IDX_W-1:0] rd_idx;
	logic [TAG_W-1:0] rd_tag;
	logic [SLOTS-1:0] tick_fire;
	logic             out_free;
	logic             emit_scan;
	logic             add_en;
	logic             tick_en;
	logic             rel_en;
	logic [IDX_W-1:0] rel_idx;
	logic [IDX_W-1:0] rel_rank;
	logic             res_load;
	cet_out_t         res_d;

	assign out_free = !out_valid_q || rsp_ready;
	assign pop = (state_q == BK_IDLE) && cmd_valid && (out_free || cmd.op == OP_TICK);

	// Lowest free slot
	always_comb begin
		free_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--)
			if (!live_q[i])
				free_idx = IDX_W'(i);
	end
	assign table_full = &live_q;

	// Fired slot holding the current scan rank (at most one matches)
	always_comb begin
		match_idx = '0;
		for (int i = 0; i < SLOTS; i++) begin
			match_vec[i] = fire_q[i] && (rank_q[i] == scan_rank_q);
			if (match_vec[i])
				match_idx = IDX_W'(i);
		end
	end
	assign any_match = |match_vec;
	assign scan_last = ((fire_q & ~match_vec) == '0);

	// Slots that reach zero on this tick
	always_comb begin
		for (int i = 0; i < SLOTS; i++)
			tick_fire[i] = live_q[i] && (ticks_q[i] == COUNT_BITS'(1));
	end

	assign hidx     = cmd.handle[IDX_W-1:0];
	assign hnd_live = cmd.handle_ok && live_q[hidx];

	// Single tag read port
	assign rd_idx = (state_q == BK_SCAN) ? match_idx : hidx;
	assign rd_tag = tag_q[rd_idx];

	assign emit_scan = (state_q == BK_SCAN) && any_match && out_free;
	assign add_en    = pop && (cmd.op == OP_ADD) && !table_full;
	assign tick_en   = pop && (cmd.op == OP_TICK);

	// Slot release: cancel of a live slot or a fired slot leaving the scan
	always_comb begin
		rel_en   = 1'b0;
		rel_idx  = hidx;
		rel_rank = rank_q[hidx];
		if (emit_scan) begin
			rel_en   = 1'b1;
			rel_idx  = match_idx;
			rel_rank = scan_rank_q;
		end else if (pop && cmd.op == OP_CANCEL && hnd_live) begin
			rel_en = 1'b1;
		end
	end

	// Next response
	always_comb begin
		res_load        = 1'b0;
		res_d.status    = ST_CLEARED;
		res_d.slot      = '0;
		res_d.event_tag = '0;
		res_d.last      = 1'b1;
		if (emit_scan) begin
			res_load        = 1'b1;
			res_d.status    = ST_FIRED;
			res_d.slot      = 4'(match_idx);
			res_d.event_tag = rd_tag;
			res_d.last      = scan_last;
		end else if (pop) begin
			unique case (cmd.op)
				OP_ADD: begin
					res_load = 1'b1;
					if (table_full) begin
						res_d.status = ST_FULL;
					end else begin
						res_d.status    = ST_ADDED;
						res_d.slot      = 4'(free_idx);
						res_d.event_tag = cmd.tag;
					end
				end
				OP_CANCEL: begin
					res_load   = 1'b1;
					res_d.slot = cmd.handle;
					if (hnd_live) begin
						res_d.status    = ST_CANCELLED;
						res_d.event_tag = rd_tag;
					end else begin
						res_d.status = ST_NOT_FOUND;
					end
				end
				OP_TICK:  res_load = 1'b0;
				OP_CLEAR: res_load = 1'b1;
				default:  res_load = 1'b0;
			endcase
		end
	end

	// Control state: sequencer, live bits, fired set, response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			live_q      <= '0;
			fire_q      <= '0;
			scan_rank_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (res_load)
				out_valid_q <= 1'b1;
			else if (rsp_ready)
				out_valid_q <= 1'b0;
			if (add_en)
				live_q[free_idx] <= 1'b1;
			if (rel_en)
				live_q[rel_idx] <= 1'b0;
			unique case (state_q)
				BK_IDLE: begin
					if (pop && cmd.op == OP_CLEAR)
						live_q <= '0;
					if (tick_en) begin
						fire_q      <= tick_fire;
						scan_rank_q <= '0;
						if (|tick_fire)
							state_q <= BK_SCAN;
					end
				end
				BK_SCAN: begin
					if (emit_scan) begin
						fire_q[match_idx] <= 1'b0;
						if (scan_last)
							state_q <= BK_IDLE;
					end else if (!any_match) begin
						scan_rank_q <= scan_rank_q + IDX_W'(1);
					end
				end
				default: state_q <= BK_IDLE;
			endcase
		end
	end

	// Slot payload: counters, tags, recency ranks
	always_ff @(posedge clk) begin
		for (int i = 0; i < SLOTS; i++) begin
			if (add_en) begin
				if (live_q[i])
					rank_q[i] <= rank_q[i] + IDX_W'(1);
				if (IDX_W'(i) == free_idx) begin
					rank_q[i]  <= '0;
					ticks_q[i] <= cmd.delay;
					tag_q[i]   <= cmd.tag;
				end
			end
			if (rel_en && live_q[i] && rank_q[i] > rel_rank)
				rank_q[i] <= rank_q[i] - IDX_W'(1);
			if (tick_en && live_q[i])
				ticks_q[i] <= ticks_q[i] - COUNT_BITS'(1);
		end
	end

	// Response register
	always_ff @(posedge clk) begin
		if (res_load)
			out_q <= res_d;
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

FILE: hw/rtl/countdown_event_table.sv
// Countdown event table: a 16-slot table of pending countdown events.
// Requests arrive on req (valid/ready); results leave on rsp (valid/ready).
// Modes: add (result: added with slot and tag, or table full), cancel by
// handle (cancelled with tag, or not found), tick (one fired result per
// event that reaches zero, newest event first, none if nothing fires) and
// clear (one cleared result). The last flag marks the final result of a
// request; a tick that fires nothing gives no result at all.
// Requests enter a two-entry command queue; the back end drains it.
// An add, cancel or clear result passes through the command queue and the
// response register. A tick first counts down every live event at once, then
// scans over recency ranks, one rank or one fired event per cycle, a fired
// event only while the receiver takes results; no new command is taken meanwhile.
// Reset empties the table and the queue; no clearing pass is needed.
// When the receiver stalls, the result is held in the response register,
// the back end takes only ticks, and req_ready drops once the queue fills.
// Depends on cet_pkg, cet_front, cet_cmd_fifo and cet_back.
module countdown_event_table (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  cet_pkg::cet_in_t  req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output cet_pkg::cet_out_t rsp
);
	import cet_pkg::*;

	logic     push;
	cet_cmd_t push_cmd;
	logic     fifo_full;
	logic     fifo_empty;
	logic     pop;
	cet_cmd_t head;

	cet_front u_front (
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.fifo_full (fifo_full),
		.push      (push),
		.push_cmd  (push_cmd)
	);

	cet_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (fifo_full),
		.pop      (pop),
		.empty    (fifo_empty),
		.head     (head)
	);

	cet_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (!fifo_empty),
		.cmd       (head),
		.pop       (pop),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

FILE: hw/rtl/cet_checker.sv
// Port-level checker for the countdown event table, bound to the top level.
// Depends on cet_pkg and countdown_event_table_assert.svh.
`include "countdown_event_table_assert.svh"

module cet_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input cet_pkg::cet_in_t  req,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input cet_pkg::cet_out_t rsp
);
	import cet_pkg::*;

	// A stalled result stays put
	`CET_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "rsp changed while stalled")

	// Only fired results come in groups; everything else closes its request
	`CET_ASSERT_IMP(a_single_last, rsp_valid && rsp.status != ST_FIRED, rsp.last, "non-fired result without last")

	// Full and cleared results carry no slot or tag
	`CET_ASSERT_IMP(a_zero_payload, rsp_valid && (rsp.status == ST_FULL || rsp.status == ST_CLEARED), rsp.slot == 4'd0 && rsp.event_tag == 16'd0, "full or cleared result with payload")

	// Not found reports no tag
	`CET_ASSERT_IMP(a_notfound_tag, rsp_valid && rsp.status == ST_NOT_FOUND, rsp.event_tag == 16'd0, "not found result with tag")

endmodule

bind countdown_event_table cet_checker u_cet_checker (.*);
